>>> design/lcg_pkg.sv
// lcg_pkg: shared constants, register indexes and the divider cell payload
// for the linear color gradient block
// depends on nothing
package lcg_pkg;

   // largest effective gradient length
   localparam int MAX_SPAN = 4096;

   // fixed field widths
   localparam int POS_W   = 12;
   localparam int COLOR_W = 24;
   localparam int SPAN_W  = 13;
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;

   // two weighted terms per channel: start then end
   localparam int NUM_TERMS = 2 * NUM_CH;

   // widths derived from the span limit
   localparam int LEN_W = $clog2(MAX_SPAN + 1);
   localparam int NUM_W = CH_W + LEN_W;
   localparam int REM_W = LEN_W + CH_W;

   // one divider cell per quotient bit
   localparam int DIV_CELLS = CH_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COLOR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_COLOR = 2'd0,
      CSR_END_COLOR   = 2'd1,
      CSR_SPAN        = 2'd2
   } csr_index_type;

   // data handed from cell to cell
   typedef struct packed {
      logic                                 in_range;
      logic [LEN_W-1:0]                     len;
      logic [NUM_TERMS-1:0][REM_W-1:0]      rem;
      logic [NUM_TERMS-1:0][CH_W-1:0]       quo;
   } cell_data_type;

endpackage

>>> design/lcg_if.sv
// lcg_if: valid/ready stream interfaces for gradient requests and responses
// depends on lcg_pkg
interface lcg_req_if
   import lcg_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

interface lcg_rsp_if
   import lcg_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic            in_range;

   modport source (output valid, output red, output green, output blue,
                   output in_range, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input in_range, output ready);
endinterface

>>> design/lcg_weight.sv
// lcg_weight: first pipeline stage, range check and the six weighted products
// depends on lcg_pkg
module lcg_weight
   import lcg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  logic [POS_W-1:0]     position,
   input  logic [COLOR_W-1:0]   start_color,
   input  logic [COLOR_W-1:0]   end_color,
   input  logic [SPAN_W-1:0]    span,
   output logic                 valid_out,
   output cell_data_type        data_out
);

   logic          valid_ff, valid_in_d;
   cell_data_type data_ff, data_in_d;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] len_minus_pos;
   logic [LEN_W-1:0] pos_len;
   logic [CH_W-1:0]  chan_a;
   logic [CH_W-1:0]  chan_b;

   // saturate the span and weigh each channel
   always_comb begin
      if (32'(span) > MAX_SPAN) begin
         len = LEN_W'(MAX_SPAN);
      end else begin
         len = LEN_W'(span);
      end
      len_minus_pos = LEN_W'(32'(len) - 32'(position));
      pos_len       = LEN_W'(position);
      data_in_d.in_range = (32'(position) < 32'(len));
      data_in_d.len      = len;
      data_in_d.quo      = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         chan_a = start_color[(NUM_CH-1-c)*CH_W +: CH_W];
         chan_b = end_color[(NUM_CH-1-c)*CH_W +: CH_W];
         data_in_d.rem[2*c]   = REM_W'(NUM_W'(chan_a) * NUM_W'(len_minus_pos));
         data_in_d.rem[2*c+1] = REM_W'(NUM_W'(chan_b) * NUM_W'(pos_len));
      end
      valid_in_d = valid_in;
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_d;
      end
      if (advance) begin
         data_ff <= data_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> design/lcg_div_cell.sv
// lcg_div_cell: one restoring division step for all six terms, one quotient
// bit per cell; depends on lcg_pkg
module lcg_div_cell
   import lcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          valid_in,
   input  cell_data_type data_in,
   output logic          valid_out,
   output cell_data_type data_out
);

   logic          valid_ff;
   cell_data_type data_ff, data_in_d;
   logic [REM_W-1:0] divisor;
   logic [REM_W-1:0] diff;
   logic             take;

   // compare against the divisor aligned to the top quotient bit
   always_comb begin
      divisor   = REM_W'(data_in.len) << (CH_W - 1);
      data_in_d = data_in;
      for (int t = 0; t < NUM_TERMS; t++) begin
         take = (data_in.rem[t] >= divisor);
         diff = take ? (data_in.rem[t] - divisor) : data_in.rem[t];
         data_in_d.rem[t] = diff << 1;
         data_in_d.quo[t] = {data_in.quo[t][CH_W-2:0], take};
      end
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> design/linear_color_gradient.sv
// linear_color_gradient: top level, configuration registers, weight stage,
// chain of divider cells and response register; depends on lcg_pkg, lcg_if,
// lcg_weight and lcg_div_cell
//
//   channel  direction  transaction payload
//   req      in         position (12 bits)
//   rsp      out        red, green, blue (8 bits each), in_range
//   csr      in         csr_index, csr_data, written when csr_we is high
//
// one transaction per cycle unless stalled by rsp.ready; stages: the weight
// stage, one divider cell per quotient bit (eight), and the response register
// the whole pipeline moves together; it holds while a response waits and
// rsp.ready is low, and req.ready follows that same enable
// synchronous reset clears the valid bits and restores the register defaults
module linear_color_gradient
   import lcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lcg_req_if.sink               req,
   lcg_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [COLOR_W-1:0] start_color_ff;
   logic [COLOR_W-1:0] end_color_ff;
   logic [SPAN_W-1:0]  span_ff;

   logic          advance;
   logic          cell_valid [DIV_CELLS+1];
   cell_data_type cell_data  [DIV_CELLS+1];

   logic            rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;
   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic            in_range_ff, in_range_in;
   cell_data_type   last;
   logic [CH_W:0]   sum;
   logic [NUM_CH-1:0][CH_W-1:0] chan;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_color_ff <= '0;
         end_color_ff   <= '0;
         span_ff        <= SPAN_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_COLOR: start_color_ff <= csr_data[COLOR_W-1:0];
            CSR_END_COLOR:   end_color_ff   <= csr_data[COLOR_W-1:0];
            CSR_SPAN:        span_ff        <= csr_data[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline moves whenever the response slot is free or being taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   lcg_weight u_weight (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .valid_in    (req.valid),
      .position    (req.position),
      .start_color (start_color_ff),
      .end_color   (end_color_ff),
      .span        (span_ff),
      .valid_out   (cell_valid[0]),
      .data_out    (cell_data[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      lcg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (cell_valid[i]),
         .data_in   (cell_data[i]),
         .valid_out (cell_valid[i+1]),
         .data_out  (cell_data[i+1])
      );
   end

   // add the two truncated quotients per channel
   always_comb begin
      last = cell_data[DIV_CELLS];
      for (int c = 0; c < NUM_CH; c++) begin
         sum     = {1'b0, last.quo[2*c]} + {1'b0, last.quo[2*c+1]};
         chan[c] = last.in_range ? sum[CH_W-1:0] : '0;
      end
      red_in       = chan[0];
      green_in     = chan[1];
      blue_in      = chan[2];
      in_range_in  = last.in_range;
      rsp_valid_in = cell_valid[DIV_CELLS];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         in_range_ff <= in_range_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.red      = red_ff;
   assign rsp.green    = green_ff;
   assign rsp.blue     = blue_ff;
   assign rsp.in_range = in_range_ff;

endmodule

>>> tb/sv/linear_color_gradient_tb.sv
// linear_color_gradient_tb: self-checking testbench for the linear color gradient block,
// with a scoreboard class that predicts each color and plain tasks that drive the ports
// depends on lcg_pkg, lcg_if and the linear_color_gradient design

// one color transaction as it leaves the block
typedef struct packed {
   logic [lcg_pkg::CH_W-1:0] red;
   logic [lcg_pkg::CH_W-1:0] green;
   logic [lcg_pkg::CH_W-1:0] blue;
   logic                     in_range;
} gradient_color_type;

// shadow registers plus the queue of colors still owed by the block
class gradient_scoreboard;
   logic [lcg_pkg::COLOR_W-1:0] start_color;
   logic [lcg_pkg::COLOR_W-1:0] end_color;
   logic [lcg_pkg::SPAN_W-1:0]  span;
   gradient_color_type          owed_colors[$];
   int unsigned                 mismatches;
   int unsigned                 positions_seen;
   int unsigned                 colors_seen;

   function new();
      start_color    = '0;
      end_color      = '0;
      span           = lcg_pkg::SPAN_W'(1);
      mismatches     = 0;
      positions_seen = 0;
      colors_seen    = 0;
   endfunction

   // register writes, unknown indexes fall through
   function void write_register(logic [lcg_pkg::CSR_IDX_W-1:0] idx,
                                logic [lcg_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         lcg_pkg::CSR_START_COLOR: start_color = data;
         lcg_pkg::CSR_END_COLOR:   end_color   = data;
         lcg_pkg::CSR_SPAN:        span        = data[lcg_pkg::SPAN_W-1:0];
         default: ;
      endcase
   endfunction

   // span clipped at the largest supported length
   function int unsigned effective_span();
      return (span > lcg_pkg::MAX_SPAN) ? lcg_pkg::MAX_SPAN : span;
   endfunction

   function int unsigned pending();
      return owed_colors.size();
   endfunction

   // each weighted term truncates on its own before the sum
   function logic [lcg_pkg::CH_W-1:0] blend(int unsigned a, int unsigned b,
                                            int unsigned pos, int unsigned len);
      return lcg_pkg::CH_W'(((a * (len - pos)) / len + (b * pos) / len) & 255);
   endfunction

   function gradient_color_type predict_color(logic [lcg_pkg::POS_W-1:0] position);
      gradient_color_type color;
      int unsigned        len;
      len   = effective_span();
      color = '0;
      if (len != 0 && position < len) begin
         color.red      = blend(start_color[23:16], end_color[23:16], position, len);
         color.green    = blend(start_color[15:8], end_color[15:8], position, len);
         color.blue     = blend(start_color[7:0], end_color[7:0], position, len);
         color.in_range = 1'b1;
      end
      return color;
   endfunction

   function void note_position(logic [lcg_pkg::POS_W-1:0] position);
      owed_colors.push_back(predict_color(position));
      positions_seen++;
   endfunction

   function void check_color(gradient_color_type got);
      gradient_color_type want;
      colors_seen++;
      if (owed_colors.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: unexpected color r=%02h g=%02h b=%02h in_range=%0b",
                     $realtime, got.red, got.green, got.blue, got.in_range);
         mismatches++;
         return;
      end
      want = owed_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.in_range !== want.in_range) begin
         if (mismatches < 10) begin
            $display("%0t: color mismatch, expected r=%02h g=%02h b=%02h in_range=%0b",
                     $realtime, want.red, want.green, want.blue, want.in_range);
            $display("%0t:                 got      r=%02h g=%02h b=%02h in_range=%0b",
                     $realtime, got.red, got.green, got.blue, got.in_range);
         end
         mismatches++;
      end
   endfunction
endclass

module linear_color_gradient_tb
   import lcg_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int LATENCY      = 10;
   localparam int DRAIN_CYCLES = LATENCY + 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 100;
   localparam int NUM_PHASES   = 12;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int unsigned sender_idle_pct  = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_request     = 1'b0;
   int unsigned hold_left        = 0;
   int unsigned settings_run     = 0;

   gradient_scoreboard sb = new();

   lcg_req_if req_if ();
   lcg_rsp_if rsp_if ();

   linear_color_gradient i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, or one long hold counted here
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_position(req_if.position);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_color('{red: rsp_if.red, green: rsp_if.green, blue: rsp_if.blue,
                             in_range: rsp_if.in_range});
      end
   end

   // one register write, enable stays high for the next one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.write_register(idx, data);
      @(negedge clock);
   endtask

   // all three registers plus a stray write to the unused index
   task automatic program_gradient(input logic [COLOR_W-1:0] start_rgb,
                                   input logic [COLOR_W-1:0] end_rgb,
                                   input logic [CSR_DATA_W-1:0] span_data);
      write_csr(CSR_START_COLOR, start_rgb);
      write_csr(CSR_END_COLOR, end_rgb);
      write_csr(CSR_SPAN, span_data);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom()));
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // offer one position, called at a falling edge, returns at the next one after acceptance
   task automatic offer_position(input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.position <= pos;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // stop offering, wait for every owed color, then let the pipe go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly positions inside the span, with edges and out-of-range ones mixed in
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned len;
      int unsigned roll;
      len  = sb.effective_span();
      roll = $urandom_range(99);
      if (len == 0 || roll < 15) return POS_W'($urandom_range(4095));
      if (roll < 22) return POS_W'(len - 1);
      if (roll < 26) return '0;
      if (roll < 30 && len < MAX_SPAN) return POS_W'(len);
      return POS_W'($urandom_range(len - 1));
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 30) return '1;
      return COLOR_W'($urandom());
   endfunction

   task automatic run_phase(input idle_mode_type mode, input int count, input bit pressure);
      int n;
      sender_idle_pct    = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 22 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 22 : 0;
      if (pressure) hold_request = 1'b1;
      for (n = 0; n < count; n++) offer_position(pick_position());
      settle();
   endtask

   // main sequence
   initial begin
      logic [CSR_DATA_W-1:0] span_data;
      int                    phase;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_if.valid    = 1'b0;
      req_if.position = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults after reset: span of one, black
      offer_position(12'd0);
      offer_position(12'd1);
      offer_position(12'd4095);
      settle();

      // full span, white fading to black
      program_gradient(24'hFFFFFF, 24'h000000, CSR_DATA_W'(MAX_SPAN));
      offer_position(12'd0);
      offer_position(12'd1);
      offer_position(12'd2048);
      offer_position(12'd4095);
      settle();

      // full span, black rising to white
      program_gradient(24'h000000, 24'hFFFFFF, CSR_DATA_W'(MAX_SPAN));
      offer_position(12'd0);
      offer_position(12'd4095);
      offer_position(12'd1);
      settle();

      // span of zero: nothing is in range
      program_gradient(24'h12AB7F, 24'hED5480, 24'd0);
      offer_position(12'd0);
      offer_position(12'd4095);
      settle();

      // span above the limit saturates
      program_gradient(24'hFF00FF, 24'h00FF00, 24'd8191);
      offer_position(12'd4095);
      offer_position(12'd0);
      settle();

      // junk above the span field, leaving a span of one
      program_gradient(24'h808080, 24'h7F7F7F, 24'hFFE001);
      offer_position(12'd0);
      offer_position(12'd1);
      settle();

      // short span where both truncated terms matter
      program_gradient(24'hFFFFFF, 24'hFFFFFF, 24'd3);
      offer_position(12'd0);
      offer_position(12'd1);
      offer_position(12'd2);
      offer_position(12'd3);
      settle();

      // random settings, idling mode rotating per phase
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 6)
            0:       span_data = CSR_DATA_W'($urandom_range(1, MAX_SPAN));
            1:       span_data = CSR_DATA_W'($urandom_range(1, 16));
            2:       span_data = CSR_DATA_W'(MAX_SPAN);
            3:       span_data = CSR_DATA_W'($urandom_range(MAX_SPAN + 1, 8191));
            4:       span_data = {11'($urandom()), 13'($urandom_range(2, 64))};
            default: span_data = {11'($urandom()), 13'($urandom())};
         endcase
         program_gradient(pick_color(), pick_color(), span_data);
         run_phase(idle_mode_type'(phase % 4), PHASE_ITEMS, phase == 4);
      end

      $display("checked %0d colors from %0d positions over %0d gradient settings",
               sb.colors_seen, sb.positions_seen, settings_run);
      $display("spans zero, one, full and saturated; idle and stall mixes; one %0d-cycle hold",
               HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
